### hdl/cspe_pkg.sv
package cspe_pkg;

    localparam int unsigned T_FRAC_BITS = 16;
    localparam int unsigned T_W         = T_FRAC_BITS + 1;
    localparam int unsigned WB          = 24;
    localparam int unsigned TW_W        = WB + 1;
    localparam int unsigned PT_W        = 32;
    localparam int unsigned OP_W        = PT_W + 1;
    localparam int unsigned WGT_W       = WB + 5;
    localparam int unsigned WC_W        = 32;
    localparam int unsigned PROD_W      = OP_W + WGT_W;
    localparam int unsigned ACC_W       = 64;
    localparam int unsigned QR_W        = ACC_W - WB;
    localparam int unsigned N_STG       = 11;

    localparam logic [T_W-1:0]  T_ONE  = T_W'(1) << T_FRAC_BITS;
    localparam logic [TW_W-1:0] TW_ONE = TW_W'(1) << WB;

    // floor(x / 3) as two reciprocal steps on the high and low parts of x
    localparam int unsigned DIV3_K     = 22;
    localparam int unsigned DIV3_M_W   = 21;
    localparam logic [DIV3_M_W-1:0] DIV3_M = DIV3_M_W'(1398102);
    localparam int unsigned DIV3_SPLIT = 18;
    localparam int unsigned DIV3_HI_W  = 18;
    localparam int unsigned QH_W       = 17;
    localparam int unsigned QY_W       = 18;
    localparam int unsigned Y_W        = DIV3_SPLIT + 2;
    localparam int unsigned HP_W       = DIV3_HI_W + DIV3_M_W;
    localparam int unsigned YP_W       = Y_W + DIV3_M_W;

    typedef enum logic [1:0] {
        SPAN_LINEAR  = 2'd0,
        SPAN_CATMULL = 2'd1,
        SPAN_BSPLINE = 2'd2,
        SPAN_BEZIER  = 2'd3
    } span_t;

    function automatic logic [TW_W-1:0] mulw(input logic [TW_W-1:0] a,
                                             input logic [TW_W-1:0] b);
        logic [2*TW_W-1:0] p;
        p = (2*TW_W)'(a) * (2*TW_W)'(b);
        return p[WB+TW_W-1:WB];
    endfunction

endpackage

### hdl/cubic_span_point_eval.sv
// Channel | Signals                                   | Beat
// --------+-------------------------------------------+------------------------------
// source  | src_valid, src_stall, func, t_param, pt_* | one span point request
//         | handle_out, handle_in                     |
// result  | res_valid, res_stall, coord, saturated    | one evaluated coordinate
//
// Eleven register stages: t clamp, t powers (two multiply stages), weights, products,
// two adder stages, rounding, two divide-by-three stages, saturation.
// One beat per cycle sustained while res_stall is low.
// rst_n clears only the stage valid bits.
// Each stage holds only while it is full and the stage after it holds, so
// empty stages keep filling while a result waits on res_stall.
module cubic_span_point_eval (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 src_valid,
    output logic                                 src_stall,
    input  cspe_pkg::span_t                      func,
    input  logic        [cspe_pkg::T_W-1:0]      t_param,
    input  logic signed [cspe_pkg::PT_W-1:0]     pt_prev,
    input  logic signed [cspe_pkg::PT_W-1:0]     pt_start,
    input  logic signed [cspe_pkg::PT_W-1:0]     pt_end,
    input  logic signed [cspe_pkg::PT_W-1:0]     pt_next,
    input  logic signed [cspe_pkg::PT_W-1:0]     handle_out,
    input  logic signed [cspe_pkg::PT_W-1:0]     handle_in,
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output logic signed [cspe_pkg::PT_W-1:0]     coord,
    output logic                                 saturated
);
    import cspe_pkg::*;

    logic [N_STG:1] vld_reg;
    logic [N_STG:1] vin;
    logic [N_STG:1] adv;

    // stage 1
    span_t                  f1_reg;
    logic [TW_W-1:0]        tw1_reg, uw1_reg;
    logic signed [PT_W-1:0] pt1_reg [4];
    logic signed [OP_W-1:0] hs1_reg [2];
    // stage 2
    span_t                  f2_reg;
    logic [TW_W-1:0]        tw2_reg, uw2_reg, t22_reg, u22_reg;
    logic signed [PT_W-1:0] pt2_reg [4];
    logic signed [OP_W-1:0] hs2_reg [2];
    // stage 3
    span_t                  f3_reg;
    logic [TW_W-1:0]        tw3_reg, uw3_reg, t23_reg, t33_reg, u33_reg, m13_reg, m23_reg;
    logic signed [PT_W-1:0] pt3_reg [4];
    logic signed [OP_W-1:0] hs3_reg [2];
    // stage 4
    span_t                   f4_reg;
    logic signed [OP_W-1:0]  a4_reg [4];
    logic signed [WGT_W-1:0] w4_reg [4];
    logic signed [OP_W-1:0]  a_next [4];
    logic signed [WGT_W-1:0] w_next [4];
    // stage 5
    span_t                    f5_reg;
    logic signed [PROD_W-1:0] pr5_reg [4];
    // stage 6
    span_t                     f6_reg;
    logic signed [PROD_W:0]    s016_reg, s236_reg;
    // stage 7
    span_t                  f7_reg;
    logic                   neg7_reg;
    logic [ACC_W-1:0]       mag7_reg;
    logic signed [ACC_W-1:0] acc;
    // stage 8
    logic                   neg8_reg, d68_reg;
    logic [QR_W-1:0]        qr8_reg;
    logic [ACC_W-1:0]       rsum;
    logic [QR_W-1:0]        qr_next;
    logic                   d6_next;
    // stage 9
    logic                   neg9_reg, d69_reg;
    logic [QR_W-1:0]        qr9_reg;
    logic [QH_W-1:0]        qh9_reg;
    logic [Y_W-1:0]         y9_reg;
    logic [DIV3_HI_W-1:0]   xh, rh_full;
    logic [HP_W-1:0]        hp;
    logic [QH_W-1:0]        qh;
    // stage 10
    logic                   neg10_reg;
    logic [QR_W-1:0]        q10_reg;
    logic [YP_W-1:0]        yp;
    logic [QY_W-1:0]        qy;
    // stage 11
    logic signed [PT_W-1:0] coord_reg;
    logic                   sat_reg;
    logic                   sat_hi, sat_lo;
    logic [PT_W-1:0]        q_lo;

    logic [T_W-1:0]         t_cl;
    logic [TW_W-1:0]        tw_next;

    logic signed [WC_W-1:0] c_one, c_tw, c_uw, c_t2, c_t3, c_u3, c_m1, c_m2;
    logic signed [WC_W-1:0] wc [4];

    // flow control
    assign vin = {vld_reg[N_STG-1:1], src_valid};

    always_comb
    begin
        adv[N_STG] = !vld_reg[N_STG] || !res_stall;
        for (int k = N_STG - 1; k >= 1; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= N_STG; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vin[k];
                end
            end
        end
    end

    assign src_stall = !adv[1];
    assign res_valid = vld_reg[N_STG];
    assign coord     = coord_reg;
    assign saturated = sat_reg;

    // stage 1: clamp t, form Bezier inner controls
    assign t_cl    = (t_param > T_ONE) ? T_ONE : t_param;
    assign tw_next = TW_W'(t_cl) << (WB - T_FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            f1_reg     <= func;
            tw1_reg    <= tw_next;
            uw1_reg    <= TW_ONE - tw_next;
            pt1_reg[0] <= pt_prev;
            pt1_reg[1] <= pt_start;
            pt1_reg[2] <= pt_end;
            pt1_reg[3] <= pt_next;
            hs1_reg[0] <= OP_W'(pt_start) + OP_W'(handle_out);
            hs1_reg[1] <= OP_W'(pt_end) + OP_W'(handle_in);
        end
    end

    // stage 2: squares
    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            f2_reg  <= f1_reg;
            tw2_reg <= tw1_reg;
            uw2_reg <= uw1_reg;
            t22_reg <= mulw(tw1_reg, tw1_reg);
            u22_reg <= mulw(uw1_reg, uw1_reg);
            pt2_reg <= pt1_reg;
            hs2_reg <= hs1_reg;
        end
    end

    // stage 3: cubes and mixed terms
    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            f3_reg  <= f2_reg;
            tw3_reg <= tw2_reg;
            uw3_reg <= uw2_reg;
            t23_reg <= t22_reg;
            t33_reg <= mulw(t22_reg, tw2_reg);
            u33_reg <= mulw(u22_reg, uw2_reg);
            m13_reg <= mulw(u22_reg, tw2_reg);
            m23_reg <= mulw(uw2_reg, t22_reg);
            pt3_reg <= pt2_reg;
            hs3_reg <= hs2_reg;
        end
    end

    // stage 4: basis weights and operand select
    assign c_one = $signed(WC_W'(TW_ONE));
    assign c_tw  = $signed(WC_W'(tw3_reg));
    assign c_uw  = $signed(WC_W'(uw3_reg));
    assign c_t2  = $signed(WC_W'(t23_reg));
    assign c_t3  = $signed(WC_W'(t33_reg));
    assign c_u3  = $signed(WC_W'(u33_reg));
    assign c_m1  = $signed(WC_W'(m13_reg));
    assign c_m2  = $signed(WC_W'(m23_reg));

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            a_next[i] = OP_W'(pt3_reg[i]);
        end
        case (f3_reg)
            SPAN_CATMULL:
            begin
                wc[0] = -c_tw + c_t2 * 32'sd2 - c_t3;
                wc[1] = c_one * 32'sd2 - c_t2 * 32'sd5 + c_t3 * 32'sd3;
                wc[2] = c_tw + c_t2 * 32'sd4 - c_t3 * 32'sd3;
                wc[3] = c_t3 - c_t2;
            end
            SPAN_BSPLINE:
            begin
                wc[0] = c_one - c_tw * 32'sd3 + c_t2 * 32'sd3 - c_t3;
                wc[1] = c_one * 32'sd4 - c_t2 * 32'sd6 + c_t3 * 32'sd3;
                wc[2] = c_one + c_tw * 32'sd3 + c_t2 * 32'sd3 - c_t3 * 32'sd3;
                wc[3] = c_t3;
            end
            SPAN_BEZIER:
            begin
                a_next[0] = OP_W'(pt3_reg[1]);
                a_next[1] = hs3_reg[0];
                a_next[2] = hs3_reg[1];
                a_next[3] = OP_W'(pt3_reg[2]);
                wc[0] = c_u3;
                wc[1] = c_m1 * 32'sd3;
                wc[2] = c_m2 * 32'sd3;
                wc[3] = c_t3;
            end
            default:
            begin
                a_next[0] = OP_W'(pt3_reg[1]);
                a_next[1] = OP_W'(pt3_reg[2]);
                a_next[2] = '0;
                a_next[3] = '0;
                wc[0] = c_uw;
                wc[1] = c_tw;
                wc[2] = '0;
                wc[3] = '0;
            end
        endcase
        for (int i = 0; i < 4; i++)
        begin
            w_next[i] = wc[i][WGT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            f4_reg <= f3_reg;
            a4_reg <= a_next;
            w4_reg <= w_next;
        end
    end

    // stage 5: products
    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            f5_reg <= f4_reg;
            for (int i = 0; i < 4; i++)
            begin
                pr5_reg[i] <= PROD_W'(a4_reg[i]) * PROD_W'(w4_reg[i]);
            end
        end
    end

    // stage 6: pair sums
    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            f6_reg   <= f5_reg;
            s016_reg <= (PROD_W+1)'(pr5_reg[0]) + (PROD_W+1)'(pr5_reg[1]);
            s236_reg <= (PROD_W+1)'(pr5_reg[2]) + (PROD_W+1)'(pr5_reg[3]);
        end
    end

    // stage 7: final sum, sign and magnitude
    assign acc = ACC_W'(s016_reg) + ACC_W'(s236_reg);

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            f7_reg   <= f6_reg;
            neg7_reg <= acc[ACC_W-1];
            mag7_reg <= acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
        end
    end

    // stage 8: round half away from zero, scale out
    always_comb
    begin
        d6_next = 1'b0;
        case (f7_reg)
            SPAN_CATMULL:
            begin
                rsum    = mag7_reg + (ACC_W'(1) << WB);
                qr_next = {1'b0, rsum[ACC_W-1:WB+1]};
            end
            SPAN_BSPLINE:
            begin
                rsum    = mag7_reg + (ACC_W'(3) << WB);
                qr_next = {1'b0, rsum[ACC_W-1:WB+1]};
                d6_next = 1'b1;
            end
            default:
            begin
                rsum    = mag7_reg + (ACC_W'(1) << (WB - 1));
                qr_next = rsum[ACC_W-1:WB];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            neg8_reg <= neg7_reg;
            d68_reg  <= d6_next;
            qr8_reg  <= qr_next;
        end
    end

    // stage 9: divide by three, high part
    assign xh      = qr8_reg[DIV3_SPLIT+DIV3_HI_W-1:DIV3_SPLIT];
    assign hp      = HP_W'(xh) * HP_W'(DIV3_M);
    assign qh      = hp[DIV3_K+QH_W-1:DIV3_K];
    assign rh_full = xh - DIV3_HI_W'(qh) * DIV3_HI_W'(3);

    always_ff @(posedge clk)
    begin
        if (adv[9])
        begin
            neg9_reg <= neg8_reg;
            d69_reg  <= d68_reg;
            qr9_reg  <= qr8_reg;
            qh9_reg  <= qh;
            y9_reg   <= {rh_full[1:0], qr8_reg[DIV3_SPLIT-1:0]};
        end
    end

    // stage 10: divide by three, low part
    assign yp = YP_W'(y9_reg) * YP_W'(DIV3_M);
    assign qy = yp[DIV3_K+QY_W-1:DIV3_K];

    always_ff @(posedge clk)
    begin
        if (adv[10])
        begin
            neg10_reg <= neg9_reg;
            q10_reg   <= d69_reg ? QR_W'({qh9_reg, qy}) : qr9_reg;
        end
    end

    // stage 11: sign and saturate
    assign sat_hi = !neg10_reg && (q10_reg > ((QR_W'(1) << (PT_W - 1)) - QR_W'(1)));
    assign sat_lo = neg10_reg && (q10_reg > (QR_W'(1) << (PT_W - 1)));
    assign q_lo   = q10_reg[PT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (adv[11])
        begin
            sat_reg <= sat_hi || sat_lo;
            if (sat_hi)
            begin
                coord_reg <= $signed({1'b0, {(PT_W-1){1'b1}}});
            end
            else if (sat_lo)
            begin
                coord_reg <= $signed({1'b1, {(PT_W-1){1'b0}}});
            end
            else
            begin
                coord_reg <= neg10_reg ? $signed(-q_lo) : $signed(q_lo);
            end
        end
    end

endmodule
